// File: design/msms_pkg.sv
package msms_pkg;

	localparam int VALUE_W    = 16;
	localparam int SUM_W      = 23;
	localparam int ACC_W      = SUM_W + 1;
	localparam int SEGCNT_W   = 7;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [APB_ADDR_W-1:0] REG_SEG_COUNT = 3'd0;
	localparam logic [SEGCNT_W-1:0]   SEG_COUNT_RESET = 7'd1;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef logic signed [SUM_W-1:0] sum_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_LOOP  = 2'd1,
		ST_FINAL = 2'd2
	} step_t;

	typedef enum logic [1:0] {
		CND_NO_INPUT = 2'd0,
		CND_MORE     = 2'd1,
		CND_OUT_BUSY = 2'd2
	} cond_t;

	typedef struct packed {
		logic accept;
		logic loop;
		logic finish;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic more;
		logic out_busy;
	} stat_t;

	typedef struct packed {
		ctl_t  ctl;
		cond_t cond;
		step_t jump;
		step_t next;
	} uword_t;

	// control store: on a hit of cond go to jump, else to next
	function automatic uword_t urom(step_t s);
		uword_t w;
		case (s)
			ST_IDLE: begin
				w = '{ctl: '{accept: 1'b1, loop: 1'b0, finish: 1'b0},
					cond: CND_NO_INPUT, jump: ST_IDLE, next: ST_LOOP};
			end
			ST_LOOP: begin
				w = '{ctl: '{accept: 1'b0, loop: 1'b1, finish: 1'b0},
					cond: CND_MORE, jump: ST_LOOP, next: ST_FINAL};
			end
			ST_FINAL: begin
				w = '{ctl: '{accept: 1'b0, loop: 1'b0, finish: 1'b1},
					cond: CND_OUT_BUSY, jump: ST_FINAL, next: ST_IDLE};
			end
			default: begin
				w = '{ctl: '{accept: 1'b0, loop: 1'b0, finish: 1'b0},
					cond: CND_NO_INPUT, jump: ST_IDLE, next: ST_IDLE};
			end
		endcase
		return w;
	endfunction

	function automatic sum_t clamp_sum(logic signed [ACC_W-1:0] x);
		sum_t r;
		if (x > ACC_W'(SUM_MAX)) begin
			r = SUM_MAX;
		end else if (x < ACC_W'(SUM_MIN)) begin
			r = SUM_MIN;
		end else begin
			r = x[SUM_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: design/max_sum_m_separated_segments_top.sv
// Greatest total of exactly seg_count non-empty segments of a stream of
// signed values, neighbouring segments at least one value apart.
// Input stream: s_tdata[15:0] carries one signed value per request, s_tlast
// marks the final value of a run. Only the last request of a run yields a
// result: m_tdata[22:0] is the best sum, m_tuser says whether any selection
// fits (sum reads zero when not).
// seg_count sits at APB address 0; write it only while the block is idle.
// Each request is taken, then each level of the segment table is walked in turn
// (one read-modify-write of the table memory a cycle), then the block closes.
// A result is loaded into the output register as the closing step ends.
// s_tready is high only while waiting for a request.
// A finished result sits in the output register; the next request may be
// taken while it waits, but a further result holds the block in its closing
// step until m_tready frees the register.
// Reset clears all valid bits, the running best and the output; seg_count
// returns to 1. The state also clears after every result.
module max_sum_m_separated_segments_top #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [msms_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [msms_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [msms_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [15:0]                          s_tdata,  // value[15:0]
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [23:0]                          m_tdata,  // best_sum[22:0], zero
	output logic                                 m_tuser   // found
);
	import msms_pkg::*;

	logic [SEGCNT_W-1:0] seg_count_q;
	ctl_t                ctl;
	stat_t               stat;
	logic                more;
	logic                out_busy;
	sum_t                best_sum;
	logic                reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_SEG_COUNT[APB_ADDR_W-1:2]);
	assign prdata  = reg_hit ? {{(APB_DATA_W-SEGCNT_W){1'b0}}, seg_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= SEG_COUNT_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			seg_count_q <= pwdata[SEGCNT_W-1:0];
		end
	end

	assign stat = '{in_valid: s_tvalid, more: more, out_busy: out_busy};

	msms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	msms_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.seg_count    (seg_count_q),
		.in_value     (s_tdata),
		.in_last      (s_tlast),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_best_sum (best_sum),
		.out_found    (m_tuser),
		.more         (more),
		.out_busy     (out_busy)
	);

	assign s_tready = ctl.accept;
	assign m_tdata  = {1'b0, best_sum};

endmodule

// File: design/msms_ctrl.sv
module msms_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  msms_pkg::stat_t stat,
	output msms_pkg::ctl_t  ctl
);
	import msms_pkg::*;

	step_t  step_q;
	step_t  step_d;
	uword_t uw;
	logic   hit;

	always_comb begin
		uw = urom(step_q);
	end

	always_comb begin
		case (uw.cond)
			CND_NO_INPUT: hit = !stat.in_valid;
			CND_MORE:     hit = stat.more;
			CND_OUT_BUSY: hit = stat.out_busy;
			default:      hit = 1'b0;
		endcase
		step_d = hit ? uw.jump : uw.next;
	end

	always_comb begin
		ctl = uw.ctl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// File: design/msms_dp.sv
module msms_dp #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  msms_pkg::ctl_t                        ctl,
	input  logic [msms_pkg::SEGCNT_W-1:0]         seg_count,
	input  logic signed [msms_pkg::VALUE_W-1:0]   in_value,
	input  logic                                  in_last,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic signed [msms_pkg::SUM_W-1:0]     out_best_sum,
	output logic                                  out_found,
	output logic                                  more,
	output logic                                  out_busy
);
	import msms_pkg::*;

	localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int KW   = AW + 1;
	localparam int CMPW = (KW > SEGCNT_W) ? KW : SEGCNT_W;
	localparam logic [AW-1:0] LAST_IDX = AW'(MAX_SEGMENTS - 1);

	// each word: older best in the upper half, sum ending at previous value below
	logic [2*SUM_W-1:0] mem_q [MAX_SEGMENTS];
	logic [2*SUM_W-1:0] rdata_q;
	logic [AW-1:0]      raddr;

	logic [MAX_SEGMENTS-1:0] ev_q;
	logic [MAX_SEGMENTS-1:0] ov_q;

	logic [AW-1:0]             idx_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      last_q;
	sum_t                      prevo_q;
	logic                      prevo_v_q;
	sum_t                      overall_q;
	logic                      overall_v_q;

	logic out_valid_q;
	sum_t out_sum_q;
	logic out_found_q;

	sum_t                    ep_s;
	sum_t                    os;
	logic                    ep_v;
	logic                    ov;
	sum_t                    vx;
	logic signed [ACC_W-1:0] a1;
	logic signed [ACC_W-1:0] a2;
	sum_t                    c1;
	sum_t                    c2;
	sum_t                    best;
	logic                    ok;
	sum_t                    new_os;
	logic                    new_ov;
	logic                    is_first;
	logic [CMPW-1:0]         k_ext;
	logic                    match;
	logic                    fin_go;

	assign ep_s     = rdata_q[SUM_W-1:0];
	assign os       = rdata_q[2*SUM_W-1:SUM_W];
	assign ep_v     = ev_q[idx_q];
	assign ov       = ov_q[idx_q];
	assign is_first = (idx_q == '0);
	assign vx       = {{(SUM_W-VALUE_W){value_q[VALUE_W-1]}}, value_q};
	assign a1       = {ep_s[SUM_W-1], ep_s} + {vx[SUM_W-1], vx};
	assign a2       = {prevo_q[SUM_W-1], prevo_q} + {vx[SUM_W-1], vx};
	assign c1       = clamp_sum(a1);
	assign c2       = clamp_sum(a2);
	assign k_ext    = CMPW'(idx_q) + CMPW'(1);
	assign match    = (k_ext == CMPW'(seg_count));

	always_comb begin
		ok   = is_first;
		best = vx;
		if (ep_v && (!ok || c1 > best)) begin
			best = c1;
			ok   = 1'b1;
		end
		if (!is_first && prevo_v_q && (!ok || c2 > best)) begin
			best = c2;
			ok   = 1'b1;
		end
		if (ep_v && (!ov || ep_s > os)) begin
			new_os = ep_s;
			new_ov = 1'b1;
		end else begin
			new_os = os;
			new_ov = ov;
		end
	end

	assign more     = (idx_q != LAST_IDX);
	assign out_busy = last_q && out_valid_q && !out_ready;
	assign fin_go   = ctl.finish && last_q && !out_busy;
	assign raddr    = (ctl.accept || idx_q == LAST_IDX) ? '0 : idx_q + AW'(1);

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
		if (ctl.loop) begin
			mem_q[idx_q] <= {new_os, best};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			value_q <= in_value;
		end
		if (ctl.loop) begin
			prevo_q <= os;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q        <= '0;
			ov_q        <= '0;
			idx_q       <= '0;
			last_q      <= 1'b0;
			prevo_v_q   <= 1'b0;
			overall_q   <= '0;
			overall_v_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				idx_q  <= '0;
				last_q <= in_last;
			end
			if (ctl.loop) begin
				ev_q[idx_q] <= ok;
				ov_q[idx_q] <= new_ov;
				prevo_v_q   <= ov;
				if (more) begin
					idx_q <= idx_q + AW'(1);
				end
				if (match && ok && (!overall_v_q || best > overall_q)) begin
					overall_q   <= best;
					overall_v_q <= 1'b1;
				end
			end
			if (fin_go) begin
				ev_q        <= '0;
				ov_q        <= '0;
				overall_q   <= '0;
				overall_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_sum_q   <= '0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
			out_found_q <= overall_v_q;
			out_sum_q   <= overall_v_q ? overall_q : '0;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_best_sum = out_sum_q;
	assign out_found    = out_found_q;

	a_result_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid_q && ev_q == '0 && !overall_v_q)
		else $error("result not loaded or state not cleared");

	a_older_needs_end: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q & ~ev_q) == '0)
		else $error("older best valid without end sum valid");

	a_first_level: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.loop && is_first |=> ev_q[0])
		else $error("level one not valid after an item");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_found_q |-> out_sum_q == '0)
		else $error("empty result carries a sum");

endmodule
